// ===== sv/owbm_pkg.sv =====
// owbm_pkg: shared types and timing constants for the one-wire bus master
// no dependencies
package owbm_pkg;

  typedef enum logic [2:0] {
    REQ_NONE  = 3'd0,
    REQ_RESET = 3'd1,
    REQ_WBIT  = 3'd2,
    REQ_RBIT  = 3'd3,
    REQ_WBYTE = 3'd4,
    REQ_RBYTE = 3'd5
  } owbm_req_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_HIGH  = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } owbm_phase_e;

  localparam int unsigned CntW = 10;

  localparam logic [CntW-1:0] T_RST_LOW  = 10'd500;
  localparam logic [CntW-1:0] T_RST_WAIT = 10'd70;
  localparam logic [CntW-1:0] T_RST_TAIL = 10'd420;
  localparam logic [CntW-1:0] T_W1_LOW   = 10'd6;
  localparam logic [CntW-1:0] T_W1_HIGH  = 10'd64;
  localparam logic [CntW-1:0] T_W0_LOW   = 10'd60;
  localparam logic [CntW-1:0] T_W0_HIGH  = 10'd10;
  localparam logic [CntW-1:0] T_RD_LOW   = 10'd2;
  localparam logic [CntW-1:0] T_RD_WAIT  = 10'd10;
  localparam logic [CntW-1:0] T_RD_TAIL  = 10'd55;
  localparam logic [CntW-1:0] T_DEFAULT  = 10'd1;

  localparam logic [CntW-1:0] CPU_RESET = 10'd64;
  localparam logic [1:0]      ADDR_CPU  = 2'd0;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wr_data;
    logic       line_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } owbm_out_t;

endpackage

// ===== sv/owbm_core.sv =====
// owbm_core: command sequencer state and per-cycle slot timing
// depends on owbm_pkg
module owbm_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [9:0]             cycles_per_us_i,
  input  owbm_pkg::owbm_in_t     item_i,
  output owbm_pkg::owbm_out_t    res_o
);
  import owbm_pkg::*;

  owbm_phase_e      phase_q, phase_d;
  logic [2:0]       op_q, op_d;
  logic [CntW-1:0]  ps_q, ps_d;
  logic [CntW-1:0]  us_q, us_d;
  logic [2:0]       bi_q, bi_d;
  logic [7:0]       sr_q, sr_d;
  logic             pf_q, pf_d;

  logic [CntW-1:0]  cpu;
  logic [CntW-1:0]  len;
  logic             valid_req;
  logic             wbit;
  logic             is_byte;

  assign cpu       = (cycles_per_us_i == '0) ? T_DEFAULT : cycles_per_us_i;
  assign valid_req = (item_i.req_type >= REQ_RESET) && (item_i.req_type <= REQ_RBYTE);

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    ps_d    = ps_q;
    us_d    = us_q;
    bi_d    = bi_q;
    sr_d    = sr_q;
    pf_d    = pf_q;
    res_o   = '0;
    len     = T_DEFAULT;
    wbit    = 1'b0;
    is_byte = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (valid_req) begin
        op_d = item_i.req_type;
        ps_d = '0;
        us_d = '0;
        bi_d = '0;
        case (item_i.req_type)
          REQ_WBIT:  sr_d = {7'd0, item_i.wr_data[0]};
          REQ_WBYTE: sr_d = item_i.wr_data;
          default:   sr_d = '0;
        endcase
        case (item_i.req_type)
          REQ_RESET:          phase_d = PH_RST_LOW;
          REQ_WBIT, REQ_WBYTE: phase_d = PH_WR_LOW;
          default:            phase_d = PH_RD_LOW;
        endcase
      end
    end else if (valid_req) begin
      res_o.rejected = 1'b1;
    end

    if (phase_d != PH_IDLE) begin
      res_o.busy_res  = 1'b1;
      res_o.drive_low = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) ||
                        (phase_d == PH_RD_LOW);

      if (ps_d == '0 && us_d == '0) begin
        if (phase_d == PH_RST_TAIL) begin
          pf_d = ~item_i.line_level;
        end else if (phase_d == PH_RD_TAIL && item_i.line_level) begin
          sr_d[bi_d] = 1'b1;
        end
      end

      wbit    = sr_d[bi_d];
      is_byte = (op_d == REQ_WBYTE) || (op_d == REQ_RBYTE);
      case (phase_d)
        PH_RST_LOW:  len = T_RST_LOW;
        PH_RST_WAIT: len = T_RST_WAIT;
        PH_RST_TAIL: len = T_RST_TAIL;
        PH_WR_LOW:   len = wbit ? T_W1_LOW : T_W0_LOW;
        PH_WR_HIGH:  len = wbit ? T_W1_HIGH : T_W0_HIGH;
        PH_RD_LOW:   len = T_RD_LOW;
        PH_RD_WAIT:  len = T_RD_WAIT;
        PH_RD_TAIL:  len = T_RD_TAIL;
        default:     len = T_DEFAULT;
      endcase

      ps_d = ps_d + 1'b1;
      if (ps_d >= cpu) begin
        ps_d = '0;
        us_d = us_d + 1'b1;
        if (us_d >= len) begin
          us_d = '0;
          case (phase_d)
            PH_RST_LOW:  phase_d = PH_RST_WAIT;
            PH_RST_WAIT: phase_d = PH_RST_TAIL;
            PH_WR_LOW:   phase_d = PH_WR_HIGH;
            PH_RD_LOW:   phase_d = PH_RD_WAIT;
            PH_RD_WAIT:  phase_d = PH_RD_TAIL;
            PH_WR_HIGH, PH_RD_TAIL: begin
              if (is_byte && bi_d != 3'd7) begin
                bi_d    = bi_d + 1'b1;
                phase_d = (phase_d == PH_WR_HIGH) ? PH_WR_LOW : PH_RD_LOW;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            default:     phase_d = PH_IDLE;
          endcase
          if (phase_d == PH_IDLE) begin
            res_o.done_res = 1'b1;
            if (op_d == REQ_RBIT || op_d == REQ_RBYTE) begin
              res_o.read_data = sr_d;
            end
          end
        end
      end
    end

    res_o.presence = pf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= '0;
      ps_q    <= '0;
      us_q    <= '0;
      bi_q    <= '0;
      sr_q    <= '0;
      pf_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      op_q    <= op_d;
      ps_q    <= ps_d;
      us_q    <= us_d;
      bi_q    <= bi_d;
      sr_q    <= sr_d;
      pf_q    <= pf_d;
    end
  end

endmodule

// ===== sv/one_wire_bus_master.sv =====
// one_wire_bus_master: top level with config register, sequencer and result register
// output: each result is registered and appears in the cycle after its input transaction
// throughput: one transaction per cycle while the result side keeps up
// reset: asynchronous active low, sequencer idle, cycles_per_us back to 64
// depends on owbm_pkg and owbm_core
module one_wire_bus_master (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  owbm_pkg::owbm_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output owbm_pkg::owbm_out_t   out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import owbm_pkg::*;

  logic [9:0]  cpu_q;
  logic        out_valid_q;
  owbm_out_t   out_q;
  owbm_out_t   res;
  logic        step;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CPU) ? {22'd0, cpu_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_q <= CPU_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CPU) begin
      cpu_q <= pwdata[9:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  owbm_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .cycles_per_us_i (cpu_q),
    .item_i          (in_data_i),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/owbm_checker.sv =====
// owbm_checker: port-level assertions for one_wire_bus_master, with bind
// depends on owbm_pkg
module owbm_assert_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input owbm_pkg::owbm_out_t   out_data_o
);
  import owbm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // input side only stalls behind a pending result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // done, drive and reject only while busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.done_res || out_data_o.drive_low ||
                    out_data_o.rejected) |-> out_data_o.busy_res)
    else $error("activity flagged outside a command");

  // read data only at done
  a_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.read_data == 8'd0)
    else $error("read data outside done");

endmodule

bind one_wire_bus_master owbm_assert_checker u_owbm_checker (.*);
